// File: hdl/msqc_pkg.sv
// Shared types and constants for the minimum square count classifier.
package msqc_pkg;

    // Handling of negative values, as held in the configuration register.
    localparam logic [1:0] MODE_MAGNITUDE = 2'd0;
    localparam logic [1:0] MODE_DROP      = 2'd1;
    localparam logic [1:0] MODE_ZERO_BIN  = 2'd2;
    localparam logic [1:0] MODE_ERROR     = 2'd3;
    localparam logic [1:0] MODE_RESET     = MODE_ERROR;

    // Category codes: least number of positive squares.
    localparam logic [2:0] CAT_ZERO  = 3'd0;
    localparam logic [2:0] CAT_ONE   = 3'd1;
    localparam logic [2:0] CAT_TWO   = 3'd2;
    localparam logic [2:0] CAT_THREE = 3'd3;
    localparam logic [2:0] CAT_FOUR  = 3'd4;

    // Status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // Control bits that travel with a job from the front end to the back end.
    typedef struct packed {
        logic classify;
        logic status;
    } t_job;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_PAIR,
        ST_STRIP,
        ST_DONE
    } t_state;

endpackage

// File: hdl/min_square_count_classifier_top.sv
// Top level of the minimum square count classifier: front end, job queue and back end.
// Zero, zero-bin and error items go from the sequencer's idle state straight to the result
// register; a classified item passes through the square root steps and, where needed, the
// two-square search and trailing-pair strip steps of the back end sequencer.
// Throughput: the back end takes one job at a time; the front end takes one transaction a
// cycle until the queue is full. Reset empties the block and selects error reporting.
module min_square_count_classifier_top #(
    parameter int VALUE_BITS  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input queue side.
    input  logic                         push,
    output logic                         full,
    input  logic signed [VALUE_BITS-1:0] i_value,
    // Result queue side.
    output logic                         empty,
    input  logic                         pop,
    output logic [2:0]                   o_category,
    output logic signed [VALUE_BITS-1:0] o_value_out,
    output logic                         o_status,
    // Configuration write channel for the negative mode register.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_data
);

    localparam int JOB_BITS = $bits(msqc_pkg::t_job);
    localparam int Q_WIDTH  = 2 * VALUE_BITS + JOB_BITS;

    logic [1:0]            r_mode;
    logic                  front_drop;
    logic [VALUE_BITS-1:0] front_mag;
    msqc_pkg::t_job        front_job;
    logic                  q_full;
    logic                  q_push;
    logic                  q_valid;
    logic                  q_pop;
    logic [Q_WIDTH-1:0]    q_wdata;
    logic [Q_WIDTH-1:0]    q_rdata;
    logic [VALUE_BITS-1:0] q_value;
    logic [VALUE_BITS-1:0] q_mag;
    msqc_pkg::t_job        q_job;
    logic [VALUE_BITS-1:0] back_value;

    // The register may be written at any cycle; it is only changed while idle by contract.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= msqc_pkg::MODE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // The front end decides at once whether a value needs the sequencer at all.
    msqc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_value (i_value),
        .i_mode  (r_mode),
        .o_drop  (front_drop),
        .o_mag   (front_mag),
        .o_job   (front_job)
    );

    // A dropped negative is accepted like any other transaction but never queued.
    assign full    = q_full;
    assign q_push  = push && !q_full && !front_drop;
    assign q_wdata = {i_value, front_mag, front_job};

    msqc_fifo #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign q_value = q_rdata[Q_WIDTH-1 -: VALUE_BITS];
    assign q_mag   = q_rdata[JOB_BITS +: VALUE_BITS];
    assign q_job   = q_rdata[JOB_BITS-1:0];

    // The back end holds its own result register, so it may start the next job
    // in the same cycle as the waiting result is taken.
    msqc_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job_value (q_value),
        .i_job_mag   (q_mag),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_category  (o_category),
        .o_value_out (back_value),
        .o_status    (o_status)
    );

    assign o_value_out = back_value;

endmodule

// File: hdl/msqc_front.sv
// Front end: takes an input value, applies the negative mode and forms a job.
module msqc_front #(
    parameter int VALUE_BITS = 16
) (
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [1:0]            i_mode,
    output logic                  o_drop,
    output logic [VALUE_BITS-1:0] o_mag,
    output msqc_pkg::t_job        o_job
);

    logic                  neg;
    logic [VALUE_BITS-1:0] mag;

    assign neg = i_value[VALUE_BITS-1];
    // The most negative value maps to 2^(VALUE_BITS-1), which still fits unsigned.
    assign mag = neg ? (~i_value + VALUE_BITS'(1)) : i_value;

    assign o_mag          = mag;
    assign o_drop         = neg && (i_mode == msqc_pkg::MODE_DROP);
    assign o_job.classify = (!neg || (i_mode == msqc_pkg::MODE_MAGNITUDE)) &&
                            (mag != '0);
    assign o_job.status   = (neg && (i_mode == msqc_pkg::MODE_ERROR)) ?
                            msqc_pkg::STATUS_ERROR : msqc_pkg::STATUS_OK;

endmodule

// File: hdl/msqc_fifo.sv
// Short job queue between the front end and the back end.
module msqc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

endmodule

// File: hdl/msqc_back.sv
// Back end: square root, two-square search and 4^a(8b+7) test, plus result register.
module msqc_back #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  logic [VALUE_BITS-1:0] i_job_value,
    input  logic [VALUE_BITS-1:0] i_job_mag,
    input  msqc_pkg::t_job        i_job,
    output logic                  o_job_pop,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [2:0]            o_category,
    output logic [VALUE_BITS-1:0] o_value_out,
    output logic                  o_status
);

    localparam int W  = VALUE_BITS;
    localparam int BW = W + (W % 2);
    localparam logic [W-1:0] BIT_INIT = W'(1) << (BW - 2);

    msqc_pkg::t_state r_state, n_state;

    logic [W-1:0] r_m, n_m;
    logic [W-1:0] r_x, n_x;
    logic [W-1:0] r_res, n_res;
    logic [W-1:0] r_bit, n_bit;
    logic [W-1:0] r_a, n_a;
    logic [W-1:0] r_b, n_b;
    logic [W:0]   r_a2, n_a2;
    logic [W:0]   r_b2, n_b2;
    logic [2:0]   r_cat, n_cat;
    logic [W-1:0] r_value, n_value;
    logic         r_status, n_status;

    logic         r_out_valid, n_out_valid;
    logic [2:0]   r_out_cat, n_out_cat;
    logic [W-1:0] r_out_value, n_out_value;
    logic         r_out_status, n_out_status;

    logic         out_free;
    logic         take_job;
    logic         out_write;
    logic [W:0]   trial;
    logic         sqrt_ge;
    logic [W-1:0] sqrt_x;
    logic [W-1:0] sqrt_res;
    logic         sqrt_last;
    logic [W+1:0] pair_sum;
    logic [W+1:0] m_ext;
    logic         pair_end;
    logic         pair_hit;
    logic         strip_end;

    assign out_free  = !r_out_valid || i_pop;
    assign take_job  = (r_state == msqc_pkg::ST_IDLE) && i_job_valid && out_free;
    assign o_job_pop = take_job;

    assign trial     = {1'b0, r_res} + {1'b0, r_bit};
    assign sqrt_ge   = {1'b0, r_x} >= trial;
    assign sqrt_x    = sqrt_ge ? (r_x - trial[W-1:0]) : r_x;
    assign sqrt_res  = sqrt_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    assign sqrt_last = r_bit[0];

    assign pair_sum  = {1'b0, r_a2} + {1'b0, r_b2};
    assign m_ext     = (W+2)'(r_m);
    assign pair_end  = r_a > r_b;
    assign pair_hit  = pair_sum == m_ext;
    assign strip_end = r_x[1:0] != 2'b00;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msqc_pkg::ST_IDLE: begin
                if (take_job && i_job.classify) begin
                    n_state = msqc_pkg::ST_SQRT;
                end
            end
            msqc_pkg::ST_SQRT: begin
                if (sqrt_last) begin
                    n_state = (sqrt_x == '0) ? msqc_pkg::ST_DONE : msqc_pkg::ST_PAIR;
                end
            end
            msqc_pkg::ST_PAIR: begin
                if (pair_end) begin
                    n_state = msqc_pkg::ST_STRIP;
                end else if (pair_hit) begin
                    n_state = msqc_pkg::ST_DONE;
                end
            end
            msqc_pkg::ST_STRIP: begin
                if (strip_end) begin
                    n_state = msqc_pkg::ST_DONE;
                end
            end
            msqc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = msqc_pkg::ST_IDLE;
                end
            end
            default: n_state = msqc_pkg::ST_IDLE;
        endcase
    end

    // Datapath and result register.
    always_comb begin
        n_m          = r_m;
        n_x          = r_x;
        n_res        = r_res;
        n_bit        = r_bit;
        n_a          = r_a;
        n_b          = r_b;
        n_a2         = r_a2;
        n_b2         = r_b2;
        n_cat        = r_cat;
        n_value      = r_value;
        n_status     = r_status;
        out_write    = 1'b0;
        n_out_cat    = r_out_cat;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        unique case (r_state)
            msqc_pkg::ST_IDLE: begin
                if (take_job) begin
                    if (i_job.classify) begin
                        n_m      = i_job_mag;
                        n_x      = i_job_mag;
                        n_res    = '0;
                        n_bit    = BIT_INIT;
                        n_value  = i_job_value;
                        n_status = i_job.status;
                    end else begin
                        out_write    = 1'b1;
                        n_out_cat    = msqc_pkg::CAT_ZERO;
                        n_out_value  = i_job_value;
                        n_out_status = i_job.status;
                    end
                end
            end
            msqc_pkg::ST_SQRT: begin
                n_x   = sqrt_x;
                n_res = sqrt_res;
                n_bit = r_bit >> 2;
                if (sqrt_last) begin
                    n_cat = msqc_pkg::CAT_ONE;
                    n_a   = W'(1);
                    n_a2  = (W+1)'(1);
                    n_b   = sqrt_res;
                    // The remainder gives the square of the root without a multiply.
                    n_b2  = (W+1)'(r_m - sqrt_x);
                end
            end
            msqc_pkg::ST_PAIR: begin
                if (pair_end) begin
                    n_x = r_m;
                end else if (pair_hit) begin
                    n_cat = msqc_pkg::CAT_TWO;
                end else if (pair_sum < m_ext) begin
                    n_a  = r_a + W'(1);
                    n_a2 = r_a2 + {r_a, 1'b1};
                end else begin
                    n_b  = r_b - W'(1);
                    n_b2 = r_b2 - {r_b, 1'b0} + (W+1)'(1);
                end
            end
            msqc_pkg::ST_STRIP: begin
                if (!strip_end) begin
                    n_x = r_x >> 2;
                end else begin
                    n_cat = (r_x[2:0] == 3'b111) ? msqc_pkg::CAT_FOUR : msqc_pkg::CAT_THREE;
                end
            end
            msqc_pkg::ST_DONE: begin
                if (out_free) begin
                    out_write    = 1'b1;
                    n_out_cat    = r_cat;
                    n_out_value  = r_value;
                    n_out_status = r_status;
                end
            end
            default: ;
        endcase

        if (out_write) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= msqc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m          <= n_m;
        r_x          <= n_x;
        r_res        <= n_res;
        r_bit        <= n_bit;
        r_a          <= n_a;
        r_b          <= n_b;
        r_a2         <= n_a2;
        r_b2         <= n_b2;
        r_cat        <= n_cat;
        r_value      <= n_value;
        r_status     <= n_status;
        r_out_cat    <= n_out_cat;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_empty     = !r_out_valid;
    assign o_category  = r_out_cat;
    assign o_value_out = r_out_value;
    assign o_status    = r_out_status;

endmodule

// File: verif/msqc_class_checker.sv
`timescale 1ns / 1ps
// Watches the classifier's channels, predicts every result and compares what comes out.
module msqc_class_checker #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  logic [2:0]            i_category,
    input  logic [VALUE_BITS-1:0] i_value_out,
    input  logic                  i_status,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [1:0]            i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [2:0]            category;
        logic [VALUE_BITS-1:0] value;
        logic                  status;
    } t_class_result;

    t_class_result awaited_results[$];
    logic [1:0]    neg_mode = msqc_pkg::MODE_RESET;
    int            fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int floor_root(input int m);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= m) begin
            r++;
        end
        return r;
    endfunction

    // Least number of positive squares summing to m, found by direct search for one and
    // two squares and by the three-square theorem for the rest.
    function automatic logic [2:0] square_count_of(input int m);
        int root;
        int lo;
        int hi;
        int sum;
        int t;
        if (m == 0) begin
            return msqc_pkg::CAT_ZERO;
        end
        root = floor_root(m);
        if (root * root == m) begin
            return msqc_pkg::CAT_ONE;
        end
        lo = 1;
        hi = root;
        while (lo <= hi) begin
            sum = lo * lo + hi * hi;
            if (sum == m) begin
                return msqc_pkg::CAT_TWO;
            end else if (sum < m) begin
                lo++;
            end else begin
                hi--;
            end
        end
        t = m;
        while (t % 4 == 0) begin
            t = t / 4;
        end
        return (t % 8 == 7) ? msqc_pkg::CAT_FOUR : msqc_pkg::CAT_THREE;
    endfunction

    // Appends one predicted result to the tail of the queue.
    task automatic add_awaited(input t_class_result r);
        awaited_results = {awaited_results, r};
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_class_result want;
        logic          neg;
        int            mag;
        if (!i_rst_n) begin
            neg_mode = msqc_pkg::MODE_RESET;
            awaited_results.delete();
        end else begin
            // Results leave before this edge's input is counted; no input reaches the output in the cycle it is taken.
            if (i_pop && !i_empty) begin
                if (awaited_results.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS) begin
                        $display("%0t: unexpected result, expected none, got cat %0d value %0d st %0d",
                                 $time, i_category, $signed(i_value_out), i_status);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    report_field("category", want.category, i_category);
                    report_field("value_out", $signed(want.value), $signed(i_value_out));
                    report_field("status", want.status, i_status);
                end
            end
            // An input taken at this edge still sees the mode from before any write here.
            if (i_push && !i_full) begin
                neg = i_value[VALUE_BITS-1];
                mag = neg ? -int'($signed(i_value)) : int'(i_value);
                want.value    = i_value;
                want.status   = msqc_pkg::STATUS_OK;
                want.category = msqc_pkg::CAT_ZERO;
                if (!neg) begin
                    want.category = square_count_of(mag);
                    add_awaited(want);
                end else begin
                    unique case (neg_mode)
                        msqc_pkg::MODE_MAGNITUDE: begin
                            want.category = square_count_of(mag);
                            add_awaited(want);
                        end
                        msqc_pkg::MODE_DROP: begin
                        end
                        msqc_pkg::MODE_ZERO_BIN: begin
                            add_awaited(want);
                        end
                        default: begin
                            want.status = msqc_pkg::STATUS_ERROR;
                            add_awaited(want);
                        end
                    endcase
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                neg_mode = i_cfg_data;
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fails;
    end

endmodule

// File: verif/tb_min_square_count_classifier_top.sv
`timescale 1ns / 1ps
// Testbench top for the minimum square count classifier: stimulus, result pacing and verdict.
module tb_min_square_count_classifier_top;

    localparam int VALUE_BITS = 16;
    // Long enough for a classified item to pass the back end, with a few jobs that may sit
    // in the queue ahead of it, so this comfortably covers anything still in flight.
    localparam int DRAIN_CYCLES = 1000;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASE_ITEMS  = 200;

    // Ways in which the result side takes transactions.
    typedef enum int {
        POP_ALWAYS,
        POP_COIN,
        POP_HOLD,
        POP_TOGGLE
    } t_pop_style;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         push = 1'b0;
    logic signed [VALUE_BITS-1:0] i_value = '0;
    logic                         pop = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic [1:0]                   i_cfg_data = msqc_pkg::MODE_RESET;

    logic                         full;
    logic                         empty;
    logic [2:0]                   o_category;
    logic signed [VALUE_BITS-1:0] o_value_out;
    logic                         o_status;
    logic                         o_cfg_ready;

    int         fail_count;
    int         pending;
    int         cycle_count = 0;
    t_pop_style pop_style = POP_ALWAYS;
    int         pop_left = 0;

    min_square_count_classifier_top #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_value     (i_value),
        .empty       (empty),
        .pop         (pop),
        .o_category  (o_category),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    msqc_class_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_value      (i_value),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_category   (o_category),
        .i_value_out  (o_value_out),
        .i_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The result side follows a pattern of its own: spells of taking every result, of
    // taking results at random, of holding off completely, and of alternating. Each spell
    // has a random length, so stalls meet the back end in its idle and done states alike.
    always @(posedge i_clk) begin
        if (pop_left == 0) begin
            pop_style <= t_pop_style'($urandom_range(0, 3));
            pop_left  <= $urandom_range(4, 40);
        end else begin
            pop_left <= pop_left - 1;
        end
        unique case (pop_style)
            POP_ALWAYS: pop <= 1'b1;
            POP_COIN:   pop <= 1'($urandom_range(0, 1));
            POP_HOLD:   pop <= 1'b0;
            default:    pop <= ~pop;
        endcase
    end

    // Watchdog: a hung handshake must not leave the run spinning for ever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offers one value and returns at the edge where the transaction is taken. Push is
    // left high, so back-to-back calls form a burst without a dead cycle between them.
    task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
        push    <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
    endtask

    // Gap between bursts. The value lines carry noise, which must not be taken.
    task automatic pause_sender(input int cycles);
        push    <= 1'b0;
        i_value <= VALUE_BITS'($urandom());
        repeat (cycles) @(posedge i_clk);
    endtask

    // Holds the sender back until every expected result has come, then waits out the
    // DRAIN_CYCLES margin; a dropped negative value never reaches the back end. One edge
    // is spent first so that a transaction taken at the current edge is already counted.
    task automatic wait_for_drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mixture of values: plain random words across the full range, small magnitudes,
    // negatives, values of the form 4^a(8b+7) that need four squares, sums of one or two
    // squares, and the edges of the range.
    function automatic logic signed [VALUE_BITS-1:0] random_value();
        int t;
        int k;
        int a;
        int b;
        t = 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: t = $urandom_range(0, 65535) - 32768;
            4, 5:       t = $urandom_range(0, 128) - 64;
            6:          t = -$urandom_range(1, 32768);
            7: begin
                t = 8 * $urandom_range(0, 255) + 7;
                k = $urandom_range(0, 6);
                while (k > 0 && t * 4 <= 32767) begin
                    t = t * 4;
                    k--;
                end
                if ($urandom_range(0, 1) == 1) begin
                    t = -t;
                end
            end
            8: begin
                a = $urandom_range(0, 127);
                b = $urandom_range(0, 127);
                t = a * a + (($urandom_range(0, 1) == 1) ? b * b : 0);
                if ($urandom_range(0, 1) == 1) begin
                    t = -t;
                end
            end
            default: begin
                case ($urandom_range(0, 7))
                    0:       t = 32767;
                    1:       t = -32768;
                    2:       t = 0;
                    3:       t = 1;
                    4:       t = -1;
                    5:       t = 16384;
                    6:       t = -16384;
                    default: t = 32766;
                endcase
            end
        endcase
        return t[VALUE_BITS-1:0];
    endfunction

    // One setting of the negative mode: the register is written while the block is idle,
    // a few negative values that matter in every mode go first, then random traffic in
    // bursts of random length. Some gaps are left out so that long unbroken runs occur.
    task automatic run_phase(input logic [1:0] mode);
        logic signed [VALUE_BITS-1:0] negatives[6];
        int                           burst_left;
        negatives  = '{-16'sd32768, -16'sd1, -16'sd7, -16'sd28, -16'sd25, -16'sd2};
        burst_left = 0;
        wait_for_drain();
        write_mode(mode);
        foreach (negatives[j]) begin
            send_value(negatives[j]);
        end
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    pause_sender($urandom_range(1, 12));
                end
                burst_left = $urandom_range(1, 20);
            end
            send_value(random_value());
            burst_left--;
        end
    endtask

    initial begin
        logic signed [VALUE_BITS-1:0] opening[20];
        logic [1:0]                   mode_order[7];
        // Zero, small cases of each category, values needing four squares (7, 28, 112,
        // 15, 60, 32764 and the largest positive value), a power of four, alternating bit
        // patterns, and the most negative value, all under the reset mode of error reporting.
        opening = '{16'sd0, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd7, 16'sd12,
                    16'sd15, 16'sd25, 16'sd28, 16'sd60, 16'sd112, 16'sd16384, 16'sd32767,
                    16'sd21845, -16'sd21846, -16'sd32768, -16'sd1, 16'sd32764};
        // Every mode, both extremes among them, and some settings visited twice so that
        // a change in either direction is seen.
        mode_order = '{msqc_pkg::MODE_MAGNITUDE, msqc_pkg::MODE_DROP,
                       msqc_pkg::MODE_ZERO_BIN, msqc_pkg::MODE_ERROR,
                       msqc_pkg::MODE_DROP, msqc_pkg::MODE_MAGNITUDE,
                       msqc_pkg::MODE_ZERO_BIN};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[j]) begin
            send_value(opening[j]);
        end
        foreach (mode_order[j]) begin
            run_phase(mode_order[j]);
        end

        wait_for_drain();
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
